[src/dcfir7_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfir7_pkg
// shared widths, register reset values and the front-to-back item type
// ----------------------------------------------------------------------------
package dcfir7_pkg;

	localparam int WORD_W            = 32;
	localparam int COEFF_REGS        = 7;
	localparam int CFG_IDX_W         = 3;
	localparam int TAP_COUNT_DEF     = 7;
	localparam int FRACTION_BITS_DEF = 24;
	localparam int SAMPLE_WIDTH_DEF  = 32;

	// queue between front and back, power of two so the pointers wrap by themselves
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef logic [COEFF_REGS-1:0][WORD_W-1:0] coeff_bank_t;

	// element 0 is the weight of the oldest sample
	localparam coeff_bank_t COEFF_RESET = {
		32'd503316, 32'd1845493, 32'd3690987, 32'd4697620,
		32'd3690987, 32'd1845493, 32'd503316
	};

	typedef struct packed {
		logic              restart;
		logic [WORD_W-1:0] voltage;
		logic [WORD_W-1:0] current;
	} item_t;

endpackage

[src/dcfir7_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfir7_front
// input side: takes items, sign-extends the samples and queues them
// ----------------------------------------------------------------------------
module dcfir7_front #(
	parameter int SAMPLE_WIDTH = dcfir7_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          restart,
	input  logic [dcfir7_pkg::WORD_W-1:0] voltage_sample,
	input  logic [dcfir7_pkg::WORD_W-1:0] current_sample,
	output logic                          q_valid,
	output dcfir7_pkg::item_t             q_item,
	input  logic                          q_pop
);

	dcfir7_pkg::item_t                       queue_q [dcfir7_pkg::QUEUE_DEPTH];
	logic [dcfir7_pkg::QUEUE_PTR_W-1:0]      wr_ptr_q;
	logic [dcfir7_pkg::QUEUE_PTR_W-1:0]      rd_ptr_q;
	logic [dcfir7_pkg::QUEUE_CNT_W-1:0]      cnt_q;
	logic                                    push;
	dcfir7_pkg::item_t                       entry;

	assign in_stall = (cnt_q == dcfir7_pkg::QUEUE_CNT_W'(dcfir7_pkg::QUEUE_DEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != '0);
	assign q_item   = queue_q[rd_ptr_q];

	// samples narrower than a word are sign-extended here once
	always_comb begin
		entry.restart = restart;
		entry.voltage = dcfir7_pkg::WORD_W'($signed(voltage_sample[SAMPLE_WIDTH-1:0]));
		entry.current = dcfir7_pkg::WORD_W'($signed(current_sample[SAMPLE_WIDTH-1:0]));
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[src/dcfir7_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfir7_back
// sample histories, per-tap multipliers, adder and output register
// ----------------------------------------------------------------------------
module dcfir7_back #(
	parameter int TAP_COUNT     = dcfir7_pkg::TAP_COUNT_DEF,
	parameter int FRACTION_BITS = dcfir7_pkg::FRACTION_BITS_DEF,
	parameter int SAMPLE_WIDTH  = dcfir7_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  dcfir7_pkg::item_t             q_item,
	output logic                          q_pop,
	input  dcfir7_pkg::coeff_bank_t       coeff,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [dcfir7_pkg::WORD_W-1:0] filtered_voltage,
	output logic [dcfir7_pkg::WORD_W-1:0] filtered_current
);

	localparam int W     = dcfir7_pkg::WORD_W;
	localparam int CNT_W = $clog2(TAP_COUNT + 1);

	// tap 0 holds the newest sample
	logic signed [SAMPLE_WIDTH-1:0] v_hist_q [TAP_COUNT];
	logic signed [SAMPLE_WIDTH-1:0] c_hist_q [TAP_COUNT];
	logic        [CNT_W-1:0]        count_q;

	logic signed [SAMPLE_WIDTH-1:0] v_nxt    [TAP_COUNT];
	logic signed [SAMPLE_WIDTH-1:0] c_nxt    [TAP_COUNT];
	logic        [CNT_W-1:0]        base_cnt;
	logic        [CNT_W-1:0]        count_nxt;
	logic        [CNT_W-1:0]        tap_idx  [TAP_COUNT];
	logic signed [W-1:0]            coef_tap [TAP_COUNT];
	logic signed [W-1:0]            v_ext    [TAP_COUNT];
	logic signed [W-1:0]            c_ext    [TAP_COUNT];
	logic signed [2*W-1:0]          prod_v   [TAP_COUNT];
	logic signed [2*W-1:0]          prod_c   [TAP_COUNT];

	logic                           s1_vld_q;
	logic        [W-1:0]            prod_v_s1 [TAP_COUNT];
	logic        [W-1:0]            prod_c_s1 [TAP_COUNT];
	logic        [W-1:0]            sum_v;
	logic        [W-1:0]            sum_c;

	logic                           out_vld_q;
	logic        [W-1:0]            fv_s2;
	logic        [W-1:0]            fc_s2;

	logic                           out_load;
	logic                           s1_adv;

	assign out_load = !out_vld_q || !out_stall;
	assign s1_adv   = !s1_vld_q || out_load;
	assign q_pop    = q_valid && s1_adv;

	// restart empties the window before the new pair goes in
	always_comb begin
		base_cnt  = q_item.restart ? '0 : count_q;
		count_nxt = (base_cnt == CNT_W'(TAP_COUNT)) ? base_cnt : base_cnt + 1'b1;
		v_nxt[0]  = q_item.voltage[SAMPLE_WIDTH-1:0];
		c_nxt[0]  = q_item.current[SAMPLE_WIDTH-1:0];
		for (int j = 1; j < TAP_COUNT; j++) begin
			v_nxt[j] = q_item.restart ? '0 : v_hist_q[j-1];
			c_nxt[j] = q_item.restart ? '0 : c_hist_q[j-1];
		end
	end

	// with n samples stored, tap j takes coefficient n-1-j; taps n and up get zero
	always_comb begin
		for (int j = 0; j < TAP_COUNT; j++) begin
			tap_idx[j]  = CNT_W'(count_nxt - CNT_W'(j) - CNT_W'(1));
			coef_tap[j] = '0;
			if (CNT_W'(j) < count_nxt) begin
				for (int r = 0; r < dcfir7_pkg::COEFF_REGS; r++) begin
					if (int'(tap_idx[j]) == r) begin
						coef_tap[j] = coeff[r];
					end
				end
			end
			v_ext[j]  = W'(v_nxt[j]);
			c_ext[j]  = W'(c_nxt[j]);
			prod_v[j] = coef_tap[j] * v_ext[j];
			prod_c[j] = coef_tap[j] * c_ext[j];
		end
	end

	always_comb begin
		sum_v = '0;
		sum_c = '0;
		for (int j = 0; j < TAP_COUNT; j++) begin
			sum_v = sum_v + prod_v_s1[j];
			sum_c = sum_c + prod_c_s1[j];
		end
	end

	// floor shift of the full product, low word kept
	always_ff @(posedge clk) begin
		if (q_pop) begin
			for (int j = 0; j < TAP_COUNT; j++) begin
				prod_v_s1[j] <= prod_v[j][FRACTION_BITS +: W];
				prod_c_s1[j] <= prod_c[j][FRACTION_BITS +: W];
			end
		end
		if (out_load && s1_vld_q) begin
			fv_s2 <= sum_v;
			fc_s2 <= sum_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < TAP_COUNT; j++) begin
				v_hist_q[j] <= '0;
				c_hist_q[j] <= '0;
			end
			count_q   <= '0;
			s1_vld_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (q_pop) begin
				for (int j = 0; j < TAP_COUNT; j++) begin
					v_hist_q[j] <= v_nxt[j];
					c_hist_q[j] <= c_nxt[j];
				end
				count_q <= count_nxt;
			end
			if (s1_adv) begin
				s1_vld_q <= q_valid;
			end
			if (out_load) begin
				out_vld_q <= s1_vld_q;
			end
		end
	end

	assign out_valid        = out_vld_q;
	assign filtered_voltage = fv_s2;
	assign filtered_current = fc_s2;

endmodule

[src/dual_channel_fir7_q24_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_channel_fir7_q24_core
// two-channel fir filter on voltage/current pairs with q24 coefficients
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall with restart, voltage_sample and
//   current_sample; one item is one sample pair
//   output channel: out_valid / out_stall with filtered_voltage and
//   filtered_current; exactly one result item per input item, in order
//   coefficients: cfg_we / cfg_index / cfg_data, index 0 weights the oldest
//   sample; indexes past the last coefficient are dropped; write only while idle
//   path: queue, product stage, output register; throughput: one item
//   per cycle while out_stall is low, set by the single multiply stage that
//   handles all taps of both channels in parallel
//   reset: histories and fill count cleared, coefficients back to defaults,
//   queue and pipeline emptied
//   output stall: the result holds in the output register, the product stage
//   and the two-entry queue fill behind it, then in_stall rises
// ----------------------------------------------------------------------------
module dual_channel_fir7_q24_core #(
	parameter int TAP_COUNT     = dcfir7_pkg::TAP_COUNT_DEF,
	parameter int FRACTION_BITS = dcfir7_pkg::FRACTION_BITS_DEF,
	parameter int SAMPLE_WIDTH  = dcfir7_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input items
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             restart,
	input  logic [dcfir7_pkg::WORD_W-1:0]    voltage_sample,
	input  logic [dcfir7_pkg::WORD_W-1:0]    current_sample,
	// result items
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [dcfir7_pkg::WORD_W-1:0]    filtered_voltage,
	output logic [dcfir7_pkg::WORD_W-1:0]    filtered_current,
	// coefficient writes
	input  logic                             cfg_we,
	input  logic [dcfir7_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dcfir7_pkg::WORD_W-1:0]    cfg_data
);

	dcfir7_pkg::coeff_bank_t coeff_q;
	logic                    q_valid;
	logic                    q_pop;
	dcfir7_pkg::item_t       q_item;

	// coefficient bank, one word per register index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q <= dcfir7_pkg::COEFF_RESET;
		end else if (cfg_we) begin
			for (int r = 0; r < dcfir7_pkg::COEFF_REGS; r++) begin
				if (int'(cfg_index) == r) begin
					coeff_q[r] <= cfg_data;
				end
			end
		end
	end

	// front: accept, sign-extend, queue
	dcfir7_front #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.restart        (restart),
		.voltage_sample (voltage_sample),
		.current_sample (current_sample),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.q_pop          (q_pop)
	);

	// back: history update, products, sum, output register
	dcfir7_back #(
		.TAP_COUNT     (TAP_COUNT),
		.FRACTION_BITS (FRACTION_BITS),
		.SAMPLE_WIDTH  (SAMPLE_WIDTH)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_valid          (q_valid),
		.q_item           (q_item),
		.q_pop            (q_pop),
		.coeff            (coeff_q),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.filtered_voltage (filtered_voltage),
		.filtered_current (filtered_current)
	);

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the two-channel 7-tap q24 fir core
// ----------------------------------------------------------------------------
// A clocked driver feeds sample pair items from a queue that the stimulus
// process fills. A clocked monitor checks every filtered result against an
// in-bench model of both histories and the coefficient bank.
// The run starts with directed extremes and restarts, then goes through
// several random phases. Each phase uses its own coefficient setting, and
// the coefficients are only rewritten while the core is drained. Both
// sides idle in random bursts in phases one and three, the sender in four.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int WORD_W     = dcfir7_pkg::WORD_W;
	localparam int CFG_IDX_W  = dcfir7_pkg::CFG_IDX_W;
	localparam int COEFF_REGS = dcfir7_pkg::COEFF_REGS;

	localparam int TAPS       = dcfir7_pkg::TAP_COUNT_DEF;
	localparam int FRAC       = dcfir7_pkg::FRACTION_BITS_DEF;
	localparam int LATENCY    = 2;
	localparam int CYCLE_CAP  = 300000;
	localparam int PHASE_LEN  = 200;

	// register map: one index per coefficient, anything past the last is dropped
	localparam logic [CFG_IDX_W-1:0] REG_COEFF_FIRST = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEFF_LAST  = 3'(COEFF_REGS - 1);
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED    = 3'(COEFF_REGS);

	// coefficient settings used by the random phases
	typedef enum int {
		COEFF_DEFAULT,
		COEFF_FULL_RANGE,
		COEFF_NEAR_UNITY,
		COEFF_EXTREMES
	} coeff_style_t;

	localparam logic [WORD_W-1:0] MAX_POS = 32'h7fff_ffff;
	localparam logic [WORD_W-1:0] MAX_NEG = 32'h8000_0000;
	localparam logic [WORD_W-1:0] Q_ONE   = 32'h0100_0000;

	typedef struct packed {
		logic [WORD_W-1:0] voltage;
		logic [WORD_W-1:0] current;
	} fir_result_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #4 clk = ~clk;

	// core ports
	logic              in_valid       = 1'b0;
	logic              in_stall;
	logic              restart        = 1'b0;
	logic [WORD_W-1:0] voltage_sample = '0;
	logic [WORD_W-1:0] current_sample = '0;
	logic              out_valid;
	logic              out_stall      = 1'b0;
	logic [WORD_W-1:0] filtered_voltage;
	logic [WORD_W-1:0] filtered_current;
	logic              cfg_we         = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index   = '0;
	logic [WORD_W-1:0] cfg_data       = '0;

	dual_channel_fir7_q24_core u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.restart          (restart),
		.voltage_sample   (voltage_sample),
		.current_sample   (current_sample),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.filtered_voltage (filtered_voltage),
		.filtered_current (filtered_current),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	// model state: both histories, fill position and coefficient bank
	logic [WORD_W-1:0] coeff_reg [COEFF_REGS];
	logic [WORD_W-1:0] volt_hist [TAPS];
	logic [WORD_W-1:0] curr_hist [TAPS];
	int                wpos;
	logic              win_full;

	// items waiting for the driver, results waiting for the monitor
	dcfir7_pkg::item_t pairs_to_send [$];
	fir_result_t       pending_filtered [$];

	// stimulus controls, changed by the stimulus process with nonblocking writes
	logic send_idle_en = 1'b0;
	logic recv_idle_en = 1'b0;
	logic hold_off     = 1'b0;

	int err_count      = 0;
	int items_accepted = 0;
	int results_checked = 0;
	int restarts_sent  = 0;
	int coeff_writes   = 0;
	int cycle_count    = 0;

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	// q24 multiply: exact 64-bit product, floor shift, low word kept
	function automatic logic [WORD_W-1:0] q24_product(input logic [WORD_W-1:0] c,
			input logic [WORD_W-1:0] s);
		logic signed [63:0] a64;
		logic signed [63:0] b64;
		logic signed [63:0] p;
		a64 = $signed(c);
		b64 = $signed(s);
		p = a64 * b64;
		p = p >>> FRAC;
		return p[WORD_W-1:0];
	endfunction

	// weighted sum over one history, oldest sample first, wrapping sum
	function automatic logic [WORD_W-1:0] channel_sum(input logic [WORD_W-1:0] hist [TAPS]);
		logic [WORD_W-1:0] acc;
		int k;
		int idx;
		acc = '0;
		if (win_full) begin
			// the slot about to be overwritten holds the oldest sample
			idx = wpos;
			for (k = 0; k < TAPS; k++) begin
				acc += q24_product(coeff_reg[k], hist[idx]);
				idx = (idx + 1) % TAPS;
			end
		end else begin
			// partial window: n samples take coefficients 0..n-1
			for (k = 0; k < wpos; k++)
				acc += q24_product(coeff_reg[k], hist[k]);
		end
		return acc;
	endfunction

	// store one sample pair and return both filtered channels
	function automatic fir_result_t fir_advance(input dcfir7_pkg::item_t it);
		fir_result_t r;
		int k;
		if (it.restart) begin
			for (k = 0; k < TAPS; k++) begin
				volt_hist[k] = '0;
				curr_hist[k] = '0;
			end
			wpos = 0;
			win_full = 1'b0;
		end
		volt_hist[wpos] = it.voltage;
		curr_hist[wpos] = it.current;
		if (wpos == TAPS - 1) begin
			wpos = 0;
			win_full = 1'b1;
		end else begin
			wpos++;
		end
		r.voltage = channel_sum(volt_hist);
		r.current = channel_sum(curr_hist);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// driver: presents queued items, holds the payload while stalled
	// ------------------------------------------------------------------
	dcfir7_pkg::item_t cur_item;
	int                send_gap;
	logic              launch;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			restart <= 1'b0;
			voltage_sample <= '0;
			current_sample <= '0;
			send_gap = 0;
		end else begin
			launch = 1'b0;
			// item taken at this edge: advance the model right away
			if (in_valid && !in_stall) begin
				pending_filtered.push_back(fir_advance(cur_item));
				items_accepted++;
			end
			// free to present a new item when nothing is held on the port
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pairs_to_send.size() > 0 && !hold_off) begin
					// start a random idle burst now
					if (send_idle_en && $urandom_range(0, 5) == 0)
						send_gap = $urandom_range(0, 4);
					else
						launch = 1'b1;
				end
				if (launch) begin
					cur_item = pairs_to_send.pop_front();
					restart <= cur_item.restart;
					voltage_sample <= cur_item.voltage;
					current_sample <= cur_item.current;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: checks each accepted result, stalls in random bursts
	// ------------------------------------------------------------------
	fir_result_t want;
	int          stall_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				results_checked++;
				if (pending_filtered.size() == 0) begin
					err_count++;
					$display("%0t: unexpected result item, actual voltage %h current %h",
						$time, filtered_voltage, filtered_current);
				end else begin
					want = pending_filtered.pop_front();
					if (filtered_voltage !== want.voltage) begin
						err_count++;
						$display("%0t: filtered_voltage expected %h actual %h",
							$time, want.voltage, filtered_voltage);
					end
					if (filtered_current !== want.current) begin
						err_count++;
						$display("%0t: filtered_current expected %h actual %h",
							$time, want.current, filtered_current);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (recv_idle_en && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 4);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// watchdog
	// ------------------------------------------------------------------
	always @(posedge clk)
		cycle_count++;

	initial begin
		while (cycle_count < CYCLE_CAP)
			@(posedge clk);
		$display("%0t: run did not finish within %0d cycles", $time, CYCLE_CAP);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	// one coefficient write, only called while the core is drained
	task automatic write_coeff(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		// writes past the last coefficient leave the bank alone
		if (idx < COEFF_REGS)
			coeff_reg[idx] = data;
		coeff_writes++;
	endtask

	task automatic queue_pair(input logic r, input logic [WORD_W-1:0] v,
			input logic [WORD_W-1:0] c);
		dcfir7_pkg::item_t it;
		it.restart = r;
		it.voltage = v;
		it.current = c;
		pairs_to_send.push_back(it);
		if (r)
			restarts_sent++;
	endtask

	// wait until every queued item is taken and every result has come back
	task automatic wait_drained();
		while (pairs_to_send.size() > 0 || in_valid || pending_filtered.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// mix of extremes, values near the q24 range and full random words
	function automatic logic [WORD_W-1:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return MAX_POS;
			1: return MAX_NEG;
			2, 3: return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] pick_coeff(input coeff_style_t style, input int k);
		case (style)
			COEFF_DEFAULT: return dcfir7_pkg::COEFF_RESET[k];
			COEFF_NEAR_UNITY: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
			COEFF_EXTREMES: begin
				case ($urandom_range(0, 3))
					0: return MAX_POS;
					1: return MAX_NEG;
					2: return '0;
					default: return $urandom;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// new coefficient set, plus a dropped write past the last register
	task automatic load_coeffs(input coeff_style_t style);
		int k;
		for (k = REG_COEFF_FIRST; k <= REG_COEFF_LAST; k++)
			write_coeff(k[CFG_IDX_W-1:0], pick_coeff(style, k));
		write_coeff(REG_UNMAPPED, $urandom);
	endtask

	// random pairs; restart_odds sets how often a window is cut short
	task automatic queue_random(input int n, input int restart_odds);
		int i;
		for (i = 0; i < n; i++)
			queue_pair($urandom_range(0, restart_odds - 1) == 0, rand_sample(), rand_sample());
	endtask

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	int k;

	initial begin
		for (k = 0; k < COEFF_REGS; k++)
			coeff_reg[k] = dcfir7_pkg::COEFF_RESET[k];
		for (k = 0; k < TAPS; k++) begin
			volt_hist[k] = '0;
			curr_hist[k] = '0;
		end
		wpos = 0;
		win_full = 1'b0;

		// reset held from the start, released away from the rising edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// default coefficients: extremes of both channels, fill past a full window
		queue_pair(1'b0, MAX_POS, MAX_NEG);
		queue_pair(1'b0, MAX_NEG, MAX_POS);
		queue_pair(1'b0, '0, '0);
		queue_pair(1'b0, 32'hffff_ffff, 32'h0000_0001);
		queue_pair(1'b0, 32'h0000_0001, 32'hffff_ffff);
		queue_pair(1'b0, MAX_POS, MAX_POS);
		queue_pair(1'b0, MAX_NEG, MAX_NEG);
		queue_pair(1'b0, Q_ONE, -Q_ONE);
		// restart in the middle of a full window, then back to back
		queue_pair(1'b1, 32'h1234_5678, 32'h8765_4321);
		queue_pair(1'b1, MAX_POS, MAX_NEG);
		wait_drained();

		// largest coefficients: products leave 32 bits, sums wrap
		for (k = REG_COEFF_FIRST; k <= REG_COEFF_LAST; k++)
			write_coeff(k[CFG_IDX_W-1:0], MAX_POS);
		write_coeff(REG_UNMAPPED, 32'hdead_beef);
		for (k = 0; k < 8; k++)
			queue_pair(k == 0, k[0] ? MAX_NEG : MAX_POS, k[0] ? MAX_POS : MAX_NEG);
		wait_drained();

		// most negative coefficients against the extremes
		for (k = REG_COEFF_FIRST; k <= REG_COEFF_LAST; k++)
			write_coeff(k[CFG_IDX_W-1:0], MAX_NEG);
		queue_pair(1'b1, MAX_NEG, MAX_POS);
		queue_pair(1'b0, MAX_NEG, MAX_NEG);
		queue_pair(1'b0, MAX_POS, MAX_POS);
		queue_pair(1'b0, 32'hffff_ffff, '0);
		queue_pair(1'b1, MAX_NEG, 32'hffff_ffff);
		queue_pair(1'b0, Q_ONE, MAX_NEG);
		wait_drained();

		// defaults written back, both sides idling
		load_coeffs(COEFF_DEFAULT);
		send_idle_en <= 1'b1;
		recv_idle_en <= 1'b1;
		queue_random(PHASE_LEN, 25);
		wait_drained();

		// full range coefficients, a stretch with no idling, frequent restarts
		load_coeffs(COEFF_FULL_RANGE);
		send_idle_en <= 1'b0;
		recv_idle_en <= 1'b0;
		queue_random(PHASE_LEN, 6);
		wait_drained();

		// near unity coefficients; halfway the sender holds off until drained
		load_coeffs(COEFF_NEAR_UNITY);
		send_idle_en <= 1'b1;
		recv_idle_en <= 1'b1;
		queue_random(PHASE_LEN, 20);
		while (pairs_to_send.size() > PHASE_LEN / 2)
			@(posedge clk);
		hold_off <= 1'b1;
		@(posedge clk);
		while (in_valid || pending_filtered.size() > 0)
			@(posedge clk);
		hold_off <= 1'b0;
		wait_drained();

		// extreme coefficient mix, sender idling only
		load_coeffs(COEFF_EXTREMES);
		recv_idle_en <= 1'b0;
		queue_random(PHASE_LEN, 15);
		wait_drained();

		// last part: random coefficients, full rate both ways
		load_coeffs(COEFF_FULL_RANGE);
		send_idle_en <= 1'b0;
		recv_idle_en <= 1'b0;
		queue_random(PHASE_LEN, 30);
		wait_drained();
		repeat (LATENCY + 4) @(posedge clk);

		$display("sent %0d sample pair items with %0d restarts, %0d coefficient writes",
			items_accepted, restarts_sent, coeff_writes);
		$display("checked %0d filtered result items, %0d mismatches", results_checked, err_count);
		if (err_count == 0 && pending_filtered.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[sim.f]
src/dcfir7_pkg.sv
src/dcfir7_front.sv
src/dcfir7_back.sv
src/dual_channel_fir7_q24_core.sv
tb/tb_top.sv
